@@ rtl/ngar_pkg.sv @@
// ----------------------------------------------------------------------------
// ngar_pkg
// Shared types and constants for the noise gate with attack/release smoothing.
// ----------------------------------------------------------------------------
package ngar_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 24;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	// reset values of the configuration registers
	localparam logic [31:0] THRESHOLD_RST = 32'd8389;
	localparam logic [31:0] ATTACK_RST    = 32'd376158;
	localparam logic [31:0] RELEASE_RST   = 32'd3804;
	localparam logic [31:0] FLOOR_RST     = 32'd1678;

	typedef enum logic [1:0] {
		REG_THRESHOLD,
		REG_ATTACK,
		REG_RELEASE,
		REG_FLOOR
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_LEVEL,
		ST_GAIN,
		ST_SCALE,
		ST_APPLY,
		ST_WRITE
	} st_t;

	// operand selection for the shared multiplier
	typedef enum logic [1:0] {
		OP_SMOOTH,
		OP_GAIN,
		OP_OUT
	} op_sel_t;

	typedef struct packed {
		logic    load;
		logic    mul_en;
		op_sel_t op;
		logic    level_we;
		logic    gain_we;
		logic    out_we;
	} ctrl_t;

endpackage

@@ rtl/ngar_cfg.sv @@
// ----------------------------------------------------------------------------
// ngar_cfg
// APB register file: threshold, attack/release coefficients and range floor.
// ----------------------------------------------------------------------------
module ngar_cfg
	import ngar_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	output logic [SAMPLE_BITS-1:0] threshold_mag,
	output logic [FRAC_BITS:0]     attack_coeff,
	output logic [FRAC_BITS:0]     release_coeff,
	output logic [FRAC_BITS:0]     range_floor
);

	logic [SAMPLE_BITS-1:0] threshold_q;
	logic [FRAC_BITS:0]     attack_q;
	logic [FRAC_BITS:0]     release_q;
	logic [FRAC_BITS:0]     floor_q;
	reg_idx_t               idx;
	logic                   wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST[SAMPLE_BITS-1:0];
			attack_q    <= ATTACK_RST[FRAC_BITS:0];
			release_q   <= RELEASE_RST[FRAC_BITS:0];
			floor_q     <= FLOOR_RST[FRAC_BITS:0];
		end else if (wr_en) begin
			unique case (idx)
				REG_THRESHOLD: threshold_q <= pwdata[SAMPLE_BITS-1:0];
				REG_ATTACK:    attack_q    <= pwdata[FRAC_BITS:0];
				REG_RELEASE:   release_q   <= pwdata[FRAC_BITS:0];
				REG_FLOOR:     floor_q     <= pwdata[FRAC_BITS:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_ATTACK:    prdata = DATA_W'(attack_q);
			REG_RELEASE:   prdata = DATA_W'(release_q);
			REG_FLOOR:     prdata = DATA_W'(floor_q);
		endcase
	end

	assign threshold_mag = threshold_q;
	assign attack_coeff  = attack_q;
	assign release_coeff = release_q;
	assign range_floor   = floor_q;

endmodule

@@ rtl/ngar_mul.sv @@
// ----------------------------------------------------------------------------
// ngar_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ngar_mul #(
	parameter int AW = 32,
	parameter int BW = 26
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] prod
);

	logic signed [AW+BW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

@@ rtl/ngar_ctrl.sv @@
// ----------------------------------------------------------------------------
// ngar_ctrl
// Sequencer: three multiplier passes per sample, each followed by a post step.
// ----------------------------------------------------------------------------
module ngar_ctrl
	import ngar_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_hold,
	output logic  in_ready,
	output ctrl_t ctrl
);

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SMOOTH;
			ST_SMOOTH: state_d = ST_LEVEL;
			ST_LEVEL:  state_d = ST_GAIN;
			ST_GAIN:   state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_WRITE;
			ST_WRITE:  if (!out_hold) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.op       = OP_SMOOTH;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			ST_SMOOTH: begin
				ctrl.mul_en = 1'b1;
				ctrl.op     = OP_SMOOTH;
			end
			ST_LEVEL:  ctrl.level_we = 1'b1;
			ST_GAIN: begin
				ctrl.mul_en = 1'b1;
				ctrl.op     = OP_GAIN;
			end
			ST_SCALE:  ctrl.gain_we = 1'b1;
			ST_APPLY: begin
				ctrl.mul_en = 1'b1;
				ctrl.op     = OP_OUT;
			end
			ST_WRITE:  ctrl.out_we = !out_hold;
			default:   ctrl.op = OP_SMOOTH;
		endcase
	end

endmodule

@@ rtl/noise_gate_attack_release.sv @@
// ----------------------------------------------------------------------------
// noise_gate_attack_release
// Per-sample noise gate: threshold compare, attack/release smoothing of the
// gate level, gain mapping over the range floor, and output scaling.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+------------------------------
// input    | in_valid / in_ready  | sample_in, frame_start
// output   | out_valid / out_ready| sample_out, applied_gain
// config   | APB psel/penable     | paddr, pwdata, prdata
//
// out_valid rises after three passes through the one shared multiplier,
// each followed by an update step.
// in_ready returns the cycle after the result is loaded into the output
// register, so no new sample is taken until the previous one is written.
// A result not yet taken stalls the sequencer only in its last step.
// Reset sets the gate fully open and loads the register defaults.
// ----------------------------------------------------------------------------
module noise_gate_attack_release
	import ngar_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [FRAC_BITS:0]            applied_gain,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	localparam int AW = (SAMPLE_BITS > FRAC_BITS + 2) ? SAMPLE_BITS : FRAC_BITS + 2;
	localparam int BW = FRAC_BITS + 2;
	localparam int PW = AW + BW;
	localparam int LW = FRAC_BITS + 3;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [SAMPLE_BITS-1:0] threshold_mag;
	logic [FRAC_BITS:0]     attack_coeff;
	logic [FRAC_BITS:0]     release_coeff;
	logic [FRAC_BITS:0]     range_floor;

	ctrl_t ctrl;
	logic  out_valid_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          target_q;
	logic [FRAC_BITS:0]            gate_q;
	logic [FRAC_BITS:0]            gain_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic [FRAC_BITS:0]            applied_gain_q;

	logic [SAMPLE_BITS-1:0] mag;
	logic                   target_d;
	logic [FRAC_BITS:0]     target_val;
	logic [FRAC_BITS:0]     coeff_raw;
	logic [FRAC_BITS:0]     coeff_c;
	logic [FRAC_BITS:0]     floor_c;
	logic [FRAC_BITS:0]     inv_floor;
	logic signed [BW-1:0]   diff;
	logic signed [AW-1:0]   mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [PW-1:0]   prod;
	logic signed [PW-1:0]   prod_sh;
	logic signed [LW-1:0]   lvl_sum;
	logic [FRAC_BITS:0]     level_d;
	logic [FRAC_BITS:0]     gain_d;

	ngar_cfg #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.threshold_mag(threshold_mag),
		.attack_coeff (attack_coeff),
		.release_coeff(release_coeff),
		.range_floor  (range_floor)
	);

	ngar_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.out_hold(out_valid_q && !out_ready),
		.in_ready(in_ready),
		.ctrl    (ctrl)
	);

	ngar_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	// magnitude of the most negative sample wraps to 2^(SAMPLE_BITS-1) unsigned
	assign mag      = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
	assign target_d = (mag >= threshold_mag);

	assign target_val = target_q ? ONE : '0;
	assign coeff_raw  = (target_q && (gate_q < ONE)) ? attack_coeff : release_coeff;
	assign coeff_c    = (coeff_raw > ONE) ? ONE : coeff_raw;
	assign floor_c    = (range_floor > ONE) ? ONE : range_floor;
	assign inv_floor  = ONE - floor_c;
	assign diff       = $signed({1'b0, target_val}) - $signed({1'b0, gate_q});

	always_comb begin
		unique case (ctrl.op)
			OP_SMOOTH: begin
				mul_a = AW'(diff);
				mul_b = $signed(BW'(coeff_c));
			end
			OP_GAIN: begin
				mul_a = $signed(AW'(gate_q));
				mul_b = $signed(BW'(inv_floor));
			end
			OP_OUT: begin
				mul_a = AW'(sample_q);
				mul_b = $signed(BW'(gain_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// arithmetic shift gives the floor of the signed quotient
	assign prod_sh = prod >>> FRAC_BITS;
	assign lvl_sum = $signed({2'b00, gate_q}) + $signed(prod_sh[LW-1:0]);

	always_comb begin
		priority if (lvl_sum < 0) begin
			level_d = '0;
		end else if (lvl_sum > $signed({2'b00, ONE})) begin
			level_d = ONE;
		end else begin
			level_d = lvl_sum[FRAC_BITS:0];
		end
	end

	assign gain_d = floor_c + prod[2*FRAC_BITS:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample_in;
			target_q <= target_d;
		end
		if (ctrl.gain_we) begin
			gain_q <= gain_d;
		end
		if (ctrl.out_we) begin
			sample_out_q   <= prod_sh[SAMPLE_BITS-1:0];
			applied_gain_q <= gain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= ONE;
		end else if (ctrl.load && frame_start) begin
			gate_q <= ONE;
		end else if (ctrl.level_we) begin
			gate_q <= level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_we) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign applied_gain = applied_gain_q;

`ifndef SYNTHESIS
	a_gate_range: assert property (@(posedge clk) disable iff (!arst_n)
		gate_q <= ONE)
		else $error("gate level above unity");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.out_we))
		else $error("output valid without a result write");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_we |-> !(out_valid_q && !out_ready))
		else $error("result written over a pending transaction");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after an accepted transaction");
`endif

endmodule
